@@ src/tlvs_pkg.sv @@
// Package for the tag/length/value record store: request codes, status codes,
// payload structs and sequencer states. No dependencies.
package tlvs_pkg;

   localparam int unsigned STORE_LIMIT_DEF = 255;

   localparam logic [2:0] REQ_CREATE = 3'd0;
   localparam logic [2:0] REQ_DELETE = 3'd1;
   localparam logic [2:0] REQ_WRITE  = 3'd2;
   localparam logic [2:0] REQ_READ   = 3'd3;
   localparam logic [2:0] REQ_FIND   = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  tag;
      logic [7:0]  length;
      logic [7:0]  offset;
      logic [31:0] write_value;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [7:0]  tag_position;
      logic [7:0]  used_bytes;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND_TAG,
      S_FIND_LEN,
      S_FIND_NEXT,
      S_DISPATCH,
      S_CREATE,
      S_DEL_RD,
      S_DEL_WR,
      S_ACC,
      S_ACC_RD,
      S_DONE
   } state_type;

endpackage

@@ src/tlv_record_store.sv @@
// Tag/length/value record store: top level with sequencer and byte memory.
// Depends on tlvs_pkg.
// Each request walks the records from the start, reading tag and length of each
// record passed; create then writes tag, length and zeroed data bytes, delete
// moves every later byte down by a read and a write, and write and read go byte
// by byte, all through the single byte-memory port.
// One request at a time; the next is taken once the response is accepted.
// Reset empties the store (used length zero); memory contents are not cleared.
module tlv_record_store #(
   parameter int unsigned STORE_LIMIT = tlvs_pkg::STORE_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tlvs_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tlvs_pkg::rsp_type     rsp_data
);
   import tlvs_pkg::*;

   localparam logic [9:0] LIMIT = 10'(STORE_LIMIT);

   // byte memory, one port, registered read
   logic [7:0] mem [0:255];
   logic       mem_we;
   logic [7:0] mem_addr;
   logic [7:0] mem_wdata;
   logic [7:0] mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   state_type    state_ff, state_in;
   req_type_type req_ff;
   logic [8:0]   used_ff, used_in;
   logic [8:0]   pos_ff, pos_in;      // walk pointer / copy index
   logic [8:0]   tpos_ff, tpos_in;    // found record
   logic [7:0]   rlen_ff, rlen_in;
   logic [8:0]   cnt_ff, cnt_in;
   logic [31:0]  rval_ff, rval_in;
   logic [1:0]   status_ff, status_in;
   logic         rsp_valid_ff;

   wire accept_req = req_valid && !req_stall;
   wire rsp_taken  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   // length byte arrives from memory in the dispatch cycle
   wire [9:0] acc_end = 10'(req_ff.offset) + 10'(req_ff.length);
   wire [9:0] skip    = 10'(rlen_ff) + 10'd2;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (state_ff == S_DONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_taken) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept_req) begin
         req_ff <= req_data;
      end
      pos_ff    <= pos_in;
      tpos_ff   <= tpos_in;
      rlen_ff   <= rlen_in;
      cnt_ff    <= cnt_in;
      rval_ff   <= rval_in;
      status_ff <= status_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept_req) begin
               state_in = (req_data.req_type > REQ_FIND) ? S_DONE : S_FIND_TAG;
            end
         end
         S_FIND_TAG: begin
            if (pos_ff > used_ff || pos_ff[8]) begin
               state_in = S_DISPATCH;
            end else begin
               state_in = S_FIND_LEN;
            end
         end
         S_FIND_LEN: begin
            if (mem_rdata_ff == req_ff.tag) begin
               state_in = S_DISPATCH;
            end else begin
               state_in = S_FIND_NEXT;
            end
         end
         S_FIND_NEXT: state_in = S_FIND_TAG;
         S_DISPATCH: begin
            state_in = S_DONE;
            if (req_ff.req_type == REQ_CREATE) begin
               if (tpos_ff == '0 &&
                   10'(used_ff) + 10'(req_ff.length) + 10'd2 <= LIMIT) begin
                  state_in = S_CREATE;
               end
            end else if (tpos_ff != '0) begin
               if (req_ff.req_type == REQ_DELETE) begin
                  state_in = S_DEL_RD;
               end else if (req_ff.req_type == REQ_WRITE ||
                            req_ff.req_type == REQ_READ) begin
                  if (req_ff.length != 8'd0 && req_ff.length <= 8'd4 &&
                      acc_end <= 10'(mem_rdata_ff)) begin
                     state_in = S_ACC;
                  end
               end
            end
         end
         S_CREATE: begin
            if (cnt_ff == 9'(req_ff.length) + 9'd1) begin
               state_in = S_DONE;
            end
         end
         S_DEL_RD: begin
            if (10'(pos_ff) + skip > 10'(used_ff)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: state_in = S_DEL_RD;
         S_ACC: begin
            if (req_ff.req_type == REQ_READ) begin
               state_in = S_ACC_RD;
            end else if (cnt_ff == 9'(req_ff.length) - 9'd1) begin
               state_in = S_DONE;
            end
         end
         S_ACC_RD: begin
            state_in = (cnt_ff == 9'(req_ff.length) - 9'd1) ? S_DONE : S_ACC;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      pos_in    = pos_ff;
      tpos_in   = tpos_ff;
      rlen_in   = rlen_ff;
      cnt_in    = cnt_ff;
      rval_in   = rval_ff;
      status_in = status_ff;
      used_in   = used_ff;
      mem_we    = 1'b0;
      mem_addr  = pos_ff[7:0];
      mem_wdata = '0;
      case (state_ff)
         S_IDLE: begin
            // response fields hold until a new request is taken
            if (accept_req) begin
               pos_in    = 9'd1;
               tpos_in   = '0;
               rval_in   = '0;
               cnt_in    = '0;
               status_in = (req_data.req_type > REQ_FIND) ? ST_RANGE : ST_OK;
            end
         end
         S_FIND_TAG: begin
            mem_addr = pos_ff[7:0];
         end
         S_FIND_LEN: begin
            mem_addr = pos_ff[7:0] + 8'd1;
            if (mem_rdata_ff == req_ff.tag) begin
               tpos_in = pos_ff;
            end
         end
         S_FIND_NEXT: begin
            // step over tag, length and data bytes
            pos_in = pos_ff + 9'(mem_rdata_ff) + 9'd2;
         end
         S_DISPATCH: begin
            // length byte read in previous cycle (found or stale on miss)
            rlen_in = mem_rdata_ff;
            if (tpos_ff == '0) begin
               if (req_ff.req_type == REQ_CREATE) begin
                  if (10'(used_ff) + 10'(req_ff.length) + 10'd2 > LIMIT) begin
                     status_in = ST_FULL;
                  end else begin
                     tpos_in = used_ff + 9'd1;
                  end
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end else if (req_ff.req_type == REQ_WRITE ||
                         req_ff.req_type == REQ_READ) begin
               if (req_ff.length == 8'd0 || req_ff.length > 8'd4 ||
                   10'(req_ff.offset) + 10'(req_ff.length) > 10'(mem_rdata_ff)) begin
                  status_in = ST_RANGE;
               end
            end
            pos_in = tpos_ff;
            cnt_in = '0;
         end
         S_CREATE: begin
            mem_we   = 1'b1;
            mem_addr = 8'(tpos_ff + cnt_ff);
            if (cnt_ff == 9'd0) begin
               mem_wdata = req_ff.tag;
            end else if (cnt_ff == 9'd1) begin
               mem_wdata = req_ff.length;
            end
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff == 9'(req_ff.length) + 9'd1) begin
               used_in = 9'(10'(used_ff) + 10'(req_ff.length) + 10'd2);
            end
         end
         S_DEL_RD: begin
            mem_addr = 8'(10'(pos_ff) + skip);
            if (10'(pos_ff) + skip > 10'(used_ff)) begin
               used_in = (skip <= 10'(used_ff)) ? 9'(10'(used_ff) - skip) : '0;
            end
         end
         S_DEL_WR: begin
            mem_we    = 1'b1;
            mem_addr  = pos_ff[7:0];
            mem_wdata = mem_rdata_ff;
            pos_in    = pos_ff + 9'd1;
         end
         S_ACC: begin
            mem_addr = 8'(10'(tpos_ff) + 10'd2 + 10'(req_ff.offset) + 10'(cnt_ff));
            if (req_ff.req_type == REQ_WRITE) begin
               mem_we    = 1'b1;
               mem_wdata = 8'(req_ff.write_value >>
                  {(2'(req_ff.length - 8'd1) - 2'(cnt_ff)), 3'b000});
               cnt_in    = cnt_ff + 9'd1;
            end
         end
         S_ACC_RD: begin
            rval_in = {rval_ff[23:0], mem_rdata_ff};
            cnt_in  = cnt_ff + 9'd1;
         end
         default: begin
         end
      endcase
   end

   // response fields, driven from registers
   always_comb begin
      rsp_data.status       = status_ff;
      rsp_data.read_value   = rval_ff;
      rsp_data.tag_position = (status_ff == ST_NOT_FOUND || status_ff == ST_FULL)
                              ? 8'd0 : tpos_ff[7:0];
      rsp_data.used_bytes   = used_ff[7:0];
   end

   // checks
   a_used_limit: assert property (@(posedge clock) disable iff (reset)
      used_ff <= 9'(LIMIT)) else $error("used length beyond limit");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("accept while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid_ff) else $error("response missing");
   a_used_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff) == S_IDLE) |-> $stable(used_ff))
      else $error("used length changed while idle");

endmodule

@@ tb/tlv_record_store_tb.sv @@
// Testbench for tlv_record_store: directed and random record requests, with
// responses checked against an in-bench model of the record store.
// Depends on tlvs_pkg and tlv_record_store.
`timescale 1ns / 100ps

module tlv_record_store_tb;
   import tlvs_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 3000000;

   // request codes outside the defined set
   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type_type  req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;

   tlv_record_store uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // shadow of the store
   logic [7:0] store_mem [0:255];
   int unsigned store_used;
   rsp_type     expected_rsps [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int          hold_cycles = 0;
   bit          stall_random = 1'b0;
   bit          done_sending = 1'b0;

   function automatic int unsigned locate_tag(input logic [7:0] tg);
      int unsigned p;
      p = 1;
      while (p <= store_used && p < 256) begin
         if (store_mem[p] == tg) return p;
         p += store_mem[(p + 1) & 8'hFF] + 2;
      end
      return 0;
   endfunction

   // compute the response of one request and update the shadow store
   function automatic rsp_type store_apply(input req_type_type rq);
      rsp_type r;
      int unsigned p, skip, rl, i;
      r = '0;
      r.status = ST_OK;
      if (rq.req_type > REQ_FIND) begin
         r.status = ST_RANGE;
      end else begin
         p = locate_tag(rq.tag);
         if (rq.req_type == REQ_CREATE) begin
            if (p != 0) begin
               r.tag_position = 8'(p);
            end else if (store_used + rq.length + 2 > STORE_LIMIT_DEF) begin
               r.status = ST_FULL;
            end else begin
               r.tag_position = 8'(store_used + 1);
               store_mem[(store_used + 1) & 8'hFF] = rq.tag;
               store_mem[(store_used + 2) & 8'hFF] = rq.length;
               for (i = 0; i < rq.length; i++)
                  store_mem[(store_used + 3 + i) & 8'hFF] = 8'h00;
               store_used += rq.length + 2;
            end
         end else if (p == 0) begin
            r.status = ST_NOT_FOUND;
         end else if (rq.req_type == REQ_DELETE) begin
            skip = store_mem[(p + 1) & 8'hFF] + 2;
            r.tag_position = 8'(p);
            for (i = p; i + skip <= store_used; i++)
               store_mem[i & 8'hFF] = store_mem[(i + skip) & 8'hFF];
            store_used = (skip <= store_used) ? store_used - skip : 0;
         end else if (rq.req_type == REQ_FIND) begin
            r.tag_position = 8'(p);
         end else begin
            rl = store_mem[(p + 1) & 8'hFF];
            r.tag_position = 8'(p);
            if (rq.length < 1 || rq.length > 4 || rq.offset + rq.length > rl) begin
               r.status = ST_RANGE;
            end else if (rq.req_type == REQ_WRITE) begin
               for (i = 0; i < rq.length; i++)
                  store_mem[(p + 2 + rq.offset + i) & 8'hFF] =
                     8'(rq.write_value >> (8 * (rq.length - 1 - i)));
            end else begin
               for (i = 0; i < rq.length; i++)
                  r.read_value = {r.read_value[23:0],
                                  store_mem[(p + 2 + rq.offset + i) & 8'hFF]};
            end
         end
      end
      r.used_bytes = 8'(store_used);
      return r;
   endfunction

   // offer one request, wait until taken, then a random gap
   task automatic send_request(input req_type_type rq);
      int gap;
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(store_apply(rq));
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_type_type make_req(input logic [2:0] kind, input logic [7:0] tg,
                                             input logic [7:0] ln, input logic [7:0] off,
                                             input logic [31:0] val);
      req_type_type rq;
      rq.req_type = kind; rq.tag = tg; rq.length = ln; rq.offset = off;
      rq.write_value = val;
      return rq;
   endfunction

   // response stall: random, or a long hold when requested
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (stall_random)
         rsp_stall <= ($urandom_range(0, 3) == 0);
      else
         rsp_stall <= 1'b0;
   end

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.read_value !== e.read_value) begin
               $display("%0t: read_value exp %h got %h", $time, e.read_value,
                        rsp_data.read_value);
               error_count++;
            end
            if (rsp_data.tag_position !== e.tag_position) begin
               $display("%0t: tag_position exp %0d got %0d", $time, e.tag_position,
                        rsp_data.tag_position);
               error_count++;
            end
            if (rsp_data.used_bytes !== e.used_bytes) begin
               $display("%0t: used_bytes exp %0d got %0d", $time, e.used_bytes,
                        rsp_data.used_bytes);
               error_count++;
            end
         end
      end
   end

   // fixed edge cases
   task automatic test_directed();
      send_request(make_req(REQ_FIND, 8'h41, 8'd0, 8'd0, 32'd0));
      send_request(make_req(REQ_DELETE, 8'h41, 8'd0, 8'd0, 32'd0));
      send_request(make_req(REQ_CREATE, 8'h41, 8'd4, 8'd0, 32'd0));
      send_request(make_req(REQ_CREATE, 8'h41, 8'd9, 8'd0, 32'd0));
      send_request(make_req(REQ_CREATE, 8'h00, 8'd0, 8'd0, 32'd0));
      send_request(make_req(REQ_CREATE, 8'hFF, 8'd8, 8'd0, 32'd0));
      send_request(make_req(REQ_WRITE, 8'h41, 8'd4, 8'd0, 32'hFFFF_FFFF));
      send_request(make_req(REQ_READ, 8'h41, 8'd4, 8'd0, 32'd0));
      send_request(make_req(REQ_WRITE, 8'hFF, 8'd3, 8'd5, 32'h00A5_5A3C));
      send_request(make_req(REQ_READ, 8'hFF, 8'd2, 8'd6, 32'd0));
      send_request(make_req(REQ_WRITE, 8'hFF, 8'd0, 8'd0, 32'd0));
      send_request(make_req(REQ_READ, 8'hFF, 8'd5, 8'd0, 32'd0));
      send_request(make_req(REQ_READ, 8'hFF, 8'd2, 8'd7, 32'd0));
      send_request(make_req(REQ_READ, 8'h00, 8'd1, 8'd0, 32'd0));
      send_request(make_req(REQ_WRITE, 8'h41, 8'd1, 8'd254, 32'd0));
      send_request(make_req(REQ_UNUSED_LO, 8'h41, 8'd0, 8'd0, 32'd0));
      send_request(make_req(REQ_UNUSED_HI, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
      send_request(make_req(REQ_DELETE, 8'h00, 8'd0, 8'd0, 32'd0));
      send_request(make_req(REQ_FIND, 8'hFF, 8'd0, 8'd0, 32'd0));
      send_request(make_req(REQ_CREATE, 8'h10, 8'd255, 8'd0, 32'd0));
      send_request(make_req(REQ_CREATE, 8'h11, 8'd200, 8'd0, 32'd0));
      send_request(make_req(REQ_CREATE, 8'h12, 8'd60, 8'd0, 32'd0));
      send_request(make_req(REQ_DELETE, 8'h41, 8'd0, 8'd0, 32'd0));
      send_request(make_req(REQ_DELETE, 8'h11, 8'd0, 8'd0, 32'd0));
   endtask

   // random traffic, biased toward hits and valid accesses
   task automatic test_random(input int count);
      req_type_type rq;
      int k;
      for (k = 0; k < count; k++) begin
         rq.req_type = 3'($urandom_range(0, 4));
         if ($urandom_range(0, 19) == 0) rq.req_type = 3'($urandom_range(5, 7));
         if (rq.req_type == REQ_DELETE && $urandom_range(0, 1)) rq.req_type = REQ_WRITE;
         rq.tag = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(8'h40, 8'h47));
         rq.offset = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 254))
                                                 : 8'($urandom_range(0, 12));
         rq.write_value = $urandom;
         if (rq.req_type == REQ_CREATE)
            rq.length = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 16));
         else
            rq.length = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(1, 4));
         send_request(rq);
      end
   endtask

   // long response hold so the block backs up against its input
   task automatic test_backpressure();
      hold_cycles <= 2000;
      test_random(20);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      stall_random = 1'b1;
      test_random(450);
      test_backpressure();
      test_random(460);
      req_valid <= 1'b0;
      done_sending = 1'b1;
      wait (expected_rsps.size() == 0);
      repeat (600) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog
   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
src/tlvs_pkg.sv
src/tlv_record_store.sv
tb/tlv_record_store_tb.sv
